FILE: rtl/core/htfd_pkg.sv
`timescale 1ns / 1ps

package htfd_pkg;

    // Frame byte positions; position zero is also the idle state.
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // Frame status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CRC   = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    // CRC-8, polynomial 0x31, initial value 0xFF, no final XOR.
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Conversion constants.
    localparam logic [12:0] TEMP_SCALE  = 13'd4375;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [9:0]  HUM_SCALE   = 10'd625;

    // Job queue between the front and back parts; the depth is a power of two.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = QUEUE_AW + 1;
    localparam logic [QUEUE_CW-1:0] QUEUE_FULL = QUEUE_CW'(QUEUE_DEPTH);

    // One decoded frame, waiting to be converted.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
    } t_job;

    // One byte through the CRC, unrolled over its eight bits.
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/htfd_front.sv
`timescale 1ns / 1ps

module htfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_start,
    input  logic              i_full,
    output logic              o_push,
    output htfd_pkg::t_job    o_job
);

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic        r_tbad, n_tbad;
    logic [15:0] r_temp, n_temp;
    logic [15:0] r_hum, n_hum;

    logic        accept;
    logic [2:0]  eff_pos;
    logic [7:0]  crc_in;
    logic [7:0]  crc_next;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign eff_pos  = i_start ? htfd_pkg::POS_T_HI : r_pos;
    assign crc_in   = i_start ? htfd_pkg::CRC_INIT : r_crc;
    assign crc_next = htfd_pkg::crc_step(crc_in, i_byte);

    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_tbad = r_tbad;
        n_temp = r_temp;
        n_hum  = r_hum;
        o_push = 1'b0;
        o_job  = '0;
        if (accept) begin
            // A new frame while one is under way closes the old one as short.
            if (i_start && r_pos != htfd_pkg::POS_T_HI) begin
                o_push       = 1'b1;
                o_job.status = htfd_pkg::ST_SHORT;
            end
            if (i_start || r_pos != htfd_pkg::POS_T_HI) begin
                n_pos = eff_pos + 3'd1;
                case (eff_pos)
                    htfd_pkg::POS_T_HI: begin
                        n_temp = {i_byte, 8'd0};
                        n_crc  = crc_next;
                        n_tbad = 1'b0;
                    end
                    htfd_pkg::POS_T_LO: begin
                        n_temp = {r_temp[15:8], i_byte};
                        n_crc  = crc_next;
                    end
                    htfd_pkg::POS_T_CRC: begin
                        n_tbad = (i_byte != crc_in);
                        n_crc  = htfd_pkg::CRC_INIT;
                    end
                    htfd_pkg::POS_H_HI: begin
                        n_hum = {i_byte, 8'd0};
                        n_crc = crc_next;
                    end
                    htfd_pkg::POS_H_LO: begin
                        n_hum = {r_hum[15:8], i_byte};
                        n_crc = crc_next;
                    end
                    default: begin
                        o_push         = 1'b1;
                        o_job.status   = (r_tbad || (i_byte != crc_in)) ?
                                         htfd_pkg::ST_CRC : htfd_pkg::ST_OK;
                        o_job.temp_raw = r_temp;
                        o_job.hum_raw  = r_hum;
                        n_pos          = htfd_pkg::POS_T_HI;
                        n_crc          = htfd_pkg::CRC_INIT;
                        n_tbad         = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= htfd_pkg::POS_T_HI;
            r_crc  <= htfd_pkg::CRC_INIT;
            r_tbad <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_tbad <= n_tbad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_temp <= n_temp;
        r_hum  <= n_hum;
    end

endmodule

FILE: rtl/core/htfd_fifo.sv
`timescale 1ns / 1ps

module htfd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  htfd_pkg::t_job    i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_nonempty,
    output htfd_pkg::t_job    o_job
);

    htfd_pkg::t_job r_mem [htfd_pkg::QUEUE_DEPTH];

    logic [htfd_pkg::QUEUE_AW-1:0] r_wr, n_wr;
    logic [htfd_pkg::QUEUE_AW-1:0] r_rd, n_rd;
    logic [htfd_pkg::QUEUE_CW-1:0] r_count, n_count;

    logic do_push;
    logic do_pop;

    assign o_full     = (r_count == htfd_pkg::QUEUE_FULL);
    assign o_nonempty = (r_count != '0);
    assign o_job      = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_wr    = do_push ? r_wr + 1'b1 : r_wr;
        n_rd    = do_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

FILE: rtl/core/htfd_back.sv
`timescale 1ns / 1ps

module htfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  htfd_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [14:0]       o_temp,
    output logic [13:0]       o_hum,
    output logic [1:0]        o_status
);

    // Stage one: the two scalings.
    logic        r_s1_valid;
    logic [1:0]  r_s1_status;
    logic [28:0] r_s1_tprod;
    logic [25:0] r_s1_hprod;

    // Stage two: the output register.
    logic        r_out_valid;
    logic [14:0] r_out_temp;
    logic [13:0] r_out_hum;
    logic [1:0]  r_out_status;

    logic        s2_take;
    logic        s1_take;
    logic [15:0] temp_wide;
    logic [14:0] n_temp;
    logic [13:0] n_hum;

    assign s2_take = !r_out_valid || i_ready;
    assign s1_take = !r_s1_valid || s2_take;
    assign o_pop   = i_job_valid && s1_take;

    assign temp_wide = {1'b0, r_s1_tprod[28:14]} - htfd_pkg::TEMP_OFFSET;

    always_comb begin
        if (r_s1_status == htfd_pkg::ST_OK) begin
            n_temp = temp_wide[14:0];
            n_hum  = r_s1_hprod[25:12];
        end else begin
            n_temp = '0;
            n_hum  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_take) begin
                r_s1_valid <= i_job_valid;
            end
            if (s2_take) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_status <= i_job.status;
            r_s1_tprod  <= {13'd0, i_job.temp_raw} * {16'd0, htfd_pkg::TEMP_SCALE};
            r_s1_hprod  <= {10'd0, i_job.hum_raw} * {16'd0, htfd_pkg::HUM_SCALE};
        end
        if (s2_take && r_s1_valid) begin
            r_out_temp   <= n_temp;
            r_out_hum    <= n_hum;
            r_out_status <= r_s1_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_temp   = r_out_temp;
    assign o_hum    = r_out_hum;
    assign o_status = r_out_status;

endmodule

FILE: rtl/core/humidity_temp_frame_decoder.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata (lowest bit up)                       tuser
// s_axis    in         rx_byte[7:0]                                frame_start
// m_axis    out        temp_centi[14:0], hum_centi[28:15], pad     frame_status[1:0]
//
// One byte item is taken every clock cycle while the job queue has room; the CRC step
// is unrolled in the front part. A result passes the queue, scaling and output registers.
// Reset is synchronous and active low; it clears the byte position, CRC and all valids.
// A queue of four decoded frames lets the output stall without stopping the input
// until that queue is full.

module humidity_temp_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic        i_s_axis_tuser,   // [0] frame_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [14:0] temp_centi, [28:15] hum_centi, [31:29] zero
    output logic [1:0]  o_m_axis_tuser    // [1:0] frame_status
);

    logic           w_push;
    htfd_pkg::t_job w_push_job;
    logic           w_full;
    logic           w_nonempty;
    htfd_pkg::t_job w_head_job;
    logic           w_pop;
    logic [14:0]    w_temp;
    logic [13:0]    w_hum;

    // The front part tracks the byte position and the CRC and turns each finished
    // or broken frame into one job.
    htfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_start (i_s_axis_tuser),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    htfd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_job      (w_push_job),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_job      (w_head_job)
    );

    // The back part scales the raw words into hundredths and holds the result.
    htfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_nonempty),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_temp      (w_temp),
        .o_hum       (w_hum),
        .o_status    (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {3'd0, w_hum, w_temp};

    // A job is only ever produced when the queue has room for it.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into a full queue");

    // Failed frames carry zero readings.
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != htfd_pkg::ST_OK) |-> (o_m_axis_tdata == '0))
        else $error("non-zero readings on a failed frame");

    // Only the three defined status codes ever appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == htfd_pkg::ST_OK ||
                             o_m_axis_tuser == htfd_pkg::ST_CRC ||
                             o_m_axis_tuser == htfd_pkg::ST_SHORT))
        else $error("undefined frame status");

    // Humidity never exceeds full scale.
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_hum <= 14'd9999))
        else $error("humidity out of range");

endmodule

FILE: bench/tb_humidity_temp_frame_decoder.sv
`timescale 1ns / 1ps

package tb_htfd_bench_pkg;

    import htfd_pkg::*;

    // One converted reading as the block should present it on the master side.
    typedef struct packed {
        logic [14:0] temp_centi;
        logic [13:0] hum_centi;
        logic [1:0]  frame_status;
    } t_reading;

    // CRC-8 over one byte, most significant bit first, polynomial 0x31.
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        logic       msb;
        acc = crc ^ data;
        repeat (8) begin
            msb = acc[7];
            acc = acc << 1;
            if (msb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    // Tracks the frame being assembled from accepted byte items and keeps the
    // readings that are still owed by the block, oldest first.
    class frame_readings_board;
        t_reading    readings_due[$];
        logic [2:0]  frame_pos;
        logic [7:0]  word_crc;
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        logic        temp_word_bad;
        int          n_taken;
        int          n_ignored;
        int          n_good;
        int          n_crc_fail;
        int          n_short;
        int          n_checked;
        int          n_errors;

        function new();
            frame_pos     = POS_T_HI;
            word_crc      = CRC_INIT;
            temp_word     = '0;
            hum_word      = '0;
            temp_word_bad = 1'b0;
            n_taken       = 0;
            n_ignored     = 0;
            n_good        = 0;
            n_crc_fail    = 0;
            n_short       = 0;
            n_checked     = 0;
            n_errors      = 0;
        endfunction

        function int pending();
            return readings_due.size();
        endfunction

        function void owe(input logic [14:0] t, input logic [13:0] h, input logic [1:0] s);
            t_reading r;
            r.temp_centi   = t;
            r.hum_centi    = h;
            r.frame_status = s;
            readings_due.push_back(r);
        endfunction

        // Called for every byte item accepted on the slave side.
        function void take_byte(input logic [7:0] rx_byte, input logic frame_start);
            logic [31:0] temp_prod;
            logic [31:0] hum_prod;
            n_taken++;
            if (frame_start) begin
                // A new frame cuts off one that is still incomplete.
                if (frame_pos != POS_T_HI) begin
                    owe('0, '0, ST_SHORT);
                    n_short++;
                end
                frame_pos     = POS_T_HI;
                word_crc      = CRC_INIT;
                temp_word_bad = 1'b0;
            end else if (frame_pos == POS_T_HI) begin
                n_ignored++;
                return;
            end
            case (frame_pos)
                POS_T_HI: begin
                    temp_word = {rx_byte, 8'h00};
                    word_crc  = crc8_next(word_crc, rx_byte);
                end
                POS_T_LO: begin
                    temp_word[7:0] = rx_byte;
                    word_crc       = crc8_next(word_crc, rx_byte);
                end
                POS_T_CRC: begin
                    temp_word_bad = (rx_byte != word_crc);
                    word_crc      = CRC_INIT;
                end
                POS_H_HI: begin
                    hum_word = {rx_byte, 8'h00};
                    word_crc = crc8_next(word_crc, rx_byte);
                end
                POS_H_LO: begin
                    hum_word[7:0] = rx_byte;
                    word_crc      = crc8_next(word_crc, rx_byte);
                end
                default: begin
                    if (temp_word_bad || rx_byte != word_crc) begin
                        owe('0, '0, ST_CRC);
                        n_crc_fail++;
                    end else begin
                        // The offset is taken modulo 2^15, which gives the
                        // negative temperatures in two's complement.
                        temp_prod = 32'(temp_word) * 32'(TEMP_SCALE);
                        hum_prod  = 32'(hum_word) * 32'(HUM_SCALE);
                        owe(temp_prod[28:14] - TEMP_OFFSET[14:0], hum_prod[25:12], ST_OK);
                        n_good++;
                    end
                    frame_pos     = POS_T_HI;
                    word_crc      = CRC_INIT;
                    temp_word_bad = 1'b0;
                    return;
                end
            endcase
            frame_pos = frame_pos + 3'd1;
        endfunction

        // Called for every result item accepted on the master side.
        function void check_reading(input logic [31:0] data, input logic [1:0] user);
            t_reading want;
            if (readings_due.size() == 0) begin
                $error("reading: none expected, got tdata %h tuser %0d", data, user);
                n_errors++;
                return;
            end
            want = readings_due.pop_front();
            n_checked++;
            if (data[14:0] !== want.temp_centi) begin
                $error("temp_centi: expected %0d, got %0d",
                       $signed(want.temp_centi), $signed(data[14:0]));
                n_errors++;
            end
            if (data[28:15] !== want.hum_centi) begin
                $error("hum_centi: expected %0d, got %0d", want.hum_centi, data[28:15]);
                n_errors++;
            end
            if (user !== want.frame_status) begin
                $error("frame_status: expected %0d, got %0d", want.frame_status, user);
                n_errors++;
            end
            if (data[31:29] !== 3'b000) begin
                $error("tdata padding: expected %0d, got %0d", 3'b000, data[31:29]);
                n_errors++;
            end
        endfunction
    endclass

endpackage

module tb_humidity_temp_frame_decoder;

    import htfd_pkg::*;
    import tb_htfd_bench_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 480;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int send_idle_pct = 7;
    int recv_idle_pct = 85;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int items_sent    = 0;

    frame_readings_board board = new();

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    humidity_temp_frame_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser)
    );

    // Receiver: random back-pressure, plus a long hold-off whenever one is asked for.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_served < hold_requests) begin
                holds_served++;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_reading(m_axis_tdata, m_axis_tuser);
        end
    end

    // Offers one byte item, with random idle cycles before it, and returns once
    // the block has taken it.
    task automatic send_byte(input logic [7:0] rx_byte, input logic frame_start);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_byte;
        s_axis_tuser  <= frame_start;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        board.take_byte(rx_byte, frame_start);
    endtask

    // Sends the first n_bytes of a frame; bit 0 of crc_bad spoils the
    // temperature CRC and bit 1 the humidity CRC.
    task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                              input logic [1:0] crc_bad, input int n_bytes);
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        logic [7:0] frame_bytes [6];
        t_crc = crc8_next(crc8_next(CRC_INIT, t_word[15:8]), t_word[7:0]);
        h_crc = crc8_next(crc8_next(CRC_INIT, h_word[15:8]), h_word[7:0]);
        if (crc_bad[0]) begin
            t_crc = t_crc ^ 8'($urandom_range(1, 255));
        end
        if (crc_bad[1]) begin
            h_crc = h_crc ^ 8'($urandom_range(1, 255));
        end
        frame_bytes = '{t_word[15:8], t_word[7:0], t_crc, h_word[15:8], h_word[7:0], h_crc};
        for (int i = 0; i < n_bytes; i++) begin
            send_byte(frame_bytes[i], i == 0);
        end
        items_sent += n_bytes;
    endtask

    function automatic logic [15:0] raw_word();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            return 16'h0000;
        end else if (pick == 1) begin
            return 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    // Mostly well-formed frames with random words; some with spoilt CRCs, some
    // cut short by the next frame, and stray bytes while the block is idle.
    task automatic run_random_frames(input int quota);
        int          first_item;
        int          pick;
        logic [15:0] t_word;
        logic [15:0] h_word;
        first_item = items_sent;
        while (items_sent - first_item < quota) begin
            pick   = $urandom_range(99);
            t_word = raw_word();
            h_word = raw_word();
            if (pick < 6 && board.frame_pos == POS_T_HI) begin
                repeat ($urandom_range(1, 3)) begin
                    send_byte(8'($urandom), 1'b0);
                end
            end else if (pick < 16) begin
                send_frame(t_word, h_word, 2'b00, $urandom_range(1, 5));
            end else if (pick < 28) begin
                send_frame(t_word, h_word, 2'($urandom_range(1, 3)), 6);
            end else begin
                send_frame(t_word, h_word, 2'b00, 6);
            end
        end
    endtask

    task automatic drain_readings();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames: a stray byte while idle, both ends of the conversion
        // ranges, a frame cut off after its first byte, and each CRC failing.
        send_byte(8'hA5, 1'b0);
        send_frame(16'h0000, 16'hFFFF, 2'b00, 6);
        send_frame(16'hFFFF, 16'h0000, 2'b00, 6);
        send_frame(16'h5A5A, 16'h5A5A, 2'b00, 1);
        send_frame(16'h6667, 16'h8000, 2'b01, 6);
        send_frame(16'h1234, 16'hABCD, 2'b10, 6);
        drain_readings();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 7;
                    recv_idle_pct = 85;
                end
                1: begin
                    send_idle_pct = 85;
                    recv_idle_pct = 7;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // Hold the master side off while items keep coming, so
                    // the job queue fills and the slave side stalls.
                    hold_requests++;
                end
            endcase
            run_random_frames(PHASE_ITEMS);
            drain_readings();
        end

        repeat (12) @(posedge i_clk);
        $display("Sent %0d byte items, %0d of them ignored while idle; checked %0d readings.",
                 board.n_taken, board.n_ignored, board.n_checked);
        $display("Readings: %0d good, %0d CRC failures, %0d short frames.",
                 board.n_good, board.n_crc_fail, board.n_short);
        if (board.n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Timed out with %0d readings outstanding.", board.pending());
        $display("Mismatches found");
        $finish;
    end

endmodule
